### sv/aaf_pkg.sv
package aaf_pkg;

    localparam int CHANNELS_DEF    = 8;
    localparam int RING_BLOCKS_DEF = 64;
    localparam int Q_DEPTH         = 4;
    localparam int SLOT_W          = 12;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 64;

    localparam logic [CFG_IDX_W-1:0] REG_RX_ENABLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STREAM_ID  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FORMAT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_CODE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_DEPTH  = 3'd4;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [1:0] ST_ACCEPTED   = 2'd0;
    localparam logic [1:0] ST_IGNORED    = 2'd1;
    localparam logic [1:0] ST_OTHER      = 2'd2;
    localparam logic [1:0] ST_FORMAT_ERR = 2'd3;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_STATUS = 2'd1,
        KIND_EMPTY  = 2'd2
    } t_kind;

    // one queued command for the back end, with the status snapshot it reports
    typedef struct packed {
        t_kind              kind;
        logic [1:0]         status;
        logic               seq_err;
        logic [SLOT_W-1:0]  slot;
        logic [31:0]        ts;
        logic [31:0]        cnt_acc;
        logic [31:0]        cnt_seq;
        logic [31:0]        cnt_fmt;
        logic [31:0]        cnt_oth;
    } t_cmd;

endpackage

### sv/aaf_in_if.sv
interface aaf_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] data_byte;
    logic       end_of_frame;

    modport source (output valid, opcode, data_byte, end_of_frame, input ready);
    modport sink   (input valid, opcode, data_byte, end_of_frame, output ready);
endinterface

### sv/aaf_out_if.sv
interface aaf_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [2:0]         channel;
    logic signed [31:0] sample;
    logic               last;
    logic [1:0]         frame_status;
    logic               sequence_error;
    logic [31:0]        avtp_ts;
    logic [31:0]        accepted_count;
    logic [31:0]        seq_error_count;
    logic [31:0]        format_error_count;
    logic [31:0]        other_stream_count;

    modport source (output valid, kind, channel, sample, last, frame_status, sequence_error,
                    avtp_ts, accepted_count, seq_error_count, format_error_count,
                    other_stream_count, input ready);
    modport sink   (input valid, kind, channel, sample, last, frame_status, sequence_error,
                    avtp_ts, accepted_count, seq_error_count, format_error_count,
                    other_stream_count, output ready);
endinterface

### sv/aaf_ram.sv
module aaf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### sv/aaf_queue.sv
module aaf_queue #(
    parameter int DEPTH = aaf_pkg::Q_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  aaf_pkg::t_cmd i_cmd,
    output logic          o_ready,
    input  logic          i_pop,
    output logic          o_valid,
    output aaf_pkg::t_cmd o_cmd
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    aaf_pkg::t_cmd  r_mem [DEPTH];
    logic [PW-1:0]  r_wp, r_rp;
    logic [PW:0]    r_cnt;

    function automatic logic [PW-1:0] f_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_ready = (r_cnt != (PW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && o_ready) begin
            r_mem[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && o_ready) begin
                r_wp <= f_inc(r_wp);
            end
            if (i_pop && o_valid) begin
                r_rp <= f_inc(r_rp);
            end
            r_cnt <= r_cnt + (PW+1)'(i_push && o_ready) - (PW+1)'(i_pop && o_valid);
        end
    end
endmodule

### sv/aaf_front.sv
module aaf_front #(
    parameter int CHANNELS    = aaf_pkg::CHANNELS_DEF,
    parameter int RING_BLOCKS = aaf_pkg::RING_BLOCKS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    aaf_in_if.sink                            i_item,
    input  logic                              i_cfg_we,
    input  logic [aaf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [aaf_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_q_ready,
    output logic                              o_push,
    output aaf_pkg::t_cmd                     o_cmd,
    input  logic                              i_pop_done,
    output logic                              o_we,
    output logic [$clog2(RING_BLOCKS*CHANNELS)-1:0] o_waddr,
    output logic [31:0]                       o_wdata
);
    localparam int AW = $clog2(RING_BLOCKS * CHANNELS);
    localparam int SW = $clog2(RING_BLOCKS);
    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [15:0] ETH_HDR = 16'd14;
    localparam logic [15:0] HDR_END = 16'd38;
    localparam logic [15:0] POS_MAX = 16'hFFFF;
    localparam logic [4:0]  HB_SUBTYPE = 5'd0;
    localparam logic [4:0]  HB_SEQ     = 5'd2;
    localparam logic [4:0]  HB_FORMAT  = 5'd16;
    localparam logic [4:0]  HB_FMT_HI  = 5'd17;
    localparam logic [4:0]  HB_FMT_LO  = 5'd18;
    localparam logic [4:0]  HB_DEPTH   = 5'd19;
    localparam logic [4:0]  HB_LEN_HI  = 5'd20;
    localparam logic [4:0]  HB_LEN_LO  = 5'd21;
    localparam logic [4:0]  HB_LAST    = 5'd23;
    localparam logic [7:0]  SUBTYPE_AAF = 8'h02;

    // configuration
    logic        r_en;
    logic [63:0] r_sid;
    logic [7:0]  r_fmt, r_depth;
    logic [3:0]  r_rate;

    // frame parse state
    logic [15:0] r_pos, n_pos;
    logic        r_sub_bad, n_sub_bad, r_id_bad, n_id_bad, r_fmt_bad, n_fmt_bad;
    logic [7:0]  r_hseq, n_hseq, r_scratch, n_scratch;
    logic [31:0] r_hts, n_hts, r_asm, n_asm;
    logic [15:0] r_dlen, n_dlen;
    logic [1:0]  r_verdict, n_verdict;
    logic [CW-1:0] r_chan, n_chan;

    // pointers and history
    logic [31:0] r_pend, n_pend, r_wp, n_wp, r_rp, n_rp;
    logic [SW-1:0] r_pslot, n_pslot, r_wslot, n_wslot, r_rslot, n_rslot;
    logic [7:0]  r_prev, n_prev;
    logic        r_seen, n_seen;
    logic [31:0] r_ts, n_ts, r_acc, n_acc, r_seq, n_seq, r_fmtc, n_fmtc, r_oth, n_oth;
    logic [3:0]  r_pops;

    logic        acc_beat, sid_wr;
    logic [15:0] hp, off;
    logic [4:0]  p5;
    logic [2:0]  id_k;
    logic [15:0] fw;
    logic [1:0]  st;
    logic        se;

    function automatic logic [SW-1:0] f_slot_inc(input logic [SW-1:0] s);
        return (s == SW'(RING_BLOCKS - 1)) ? '0 : s + 1'b1;
    endfunction

    assign i_item.ready = i_q_ready && (i_item.opcode == aaf_pkg::OP_POP || r_pops == '0);
    assign acc_beat     = i_item.valid && i_item.ready;
    assign sid_wr       = i_cfg_we && (i_cfg_index == aaf_pkg::REG_STREAM_ID);
    assign hp           = r_pos - ETH_HDR;
    assign p5           = hp[4:0];
    assign id_k         = 3'(5'd11 - p5);
    assign off          = r_pos - HDR_END;
    assign fw           = {r_scratch, i_item.data_byte};

    always_comb begin
        n_pos = r_pos; n_sub_bad = r_sub_bad; n_id_bad = r_id_bad; n_fmt_bad = r_fmt_bad;
        n_hseq = r_hseq; n_scratch = r_scratch; n_hts = r_hts; n_asm = r_asm;
        n_dlen = r_dlen; n_verdict = r_verdict; n_chan = r_chan;
        n_pend = r_pend; n_wp = r_wp; n_rp = r_rp;
        n_pslot = r_pslot; n_wslot = r_wslot; n_rslot = r_rslot;
        n_prev = r_prev; n_seen = r_seen; n_ts = r_ts;
        n_acc = r_acc; n_seq = r_seq; n_fmtc = r_fmtc; n_oth = r_oth;
        o_we = 1'b0; o_waddr = '0; o_wdata = '0;
        o_push = 1'b0; st = aaf_pkg::ST_IGNORED; se = 1'b0;
        o_cmd = '0;

        if (acc_beat && i_item.opcode == aaf_pkg::OP_POP) begin
            o_push = 1'b1;
            o_cmd.cnt_acc = r_acc; o_cmd.cnt_seq = r_seq;
            o_cmd.cnt_fmt = r_fmtc; o_cmd.cnt_oth = r_oth; o_cmd.ts = r_ts;
            if (r_wp == r_rp) begin
                o_cmd.kind = aaf_pkg::KIND_EMPTY;
            end else begin
                o_cmd.kind = aaf_pkg::KIND_SAMPLE;
                o_cmd.slot = aaf_pkg::SLOT_W'(r_rslot);
                n_rp = r_rp + 32'd1;
                n_rslot = f_slot_inc(r_rslot);
            end
        end else if (acc_beat) begin
            if (r_pos == '0) begin
                n_pend = r_wp; n_pslot = r_wslot;
                n_dlen = '0; n_sub_bad = 1'b0; n_id_bad = 1'b0; n_fmt_bad = 1'b0;
                n_hseq = '0; n_hts = '0; n_scratch = '0; n_asm = '0; n_chan = '0;
                n_verdict = r_en ? aaf_pkg::ST_ACCEPTED : aaf_pkg::ST_IGNORED;
            end
            if (r_pos >= ETH_HDR && r_pos < HDR_END) begin
                priority if (p5 == HB_SUBTYPE) begin
                    if (i_item.data_byte != SUBTYPE_AAF) n_sub_bad = 1'b1;
                end else if (p5 == HB_SEQ) begin
                    n_hseq = i_item.data_byte;
                end else if (p5 >= 5'd4 && p5 <= 5'd11) begin
                    if (i_item.data_byte != r_sid[8*id_k +: 8]) n_id_bad = 1'b1;
                end else if (p5 >= 5'd12 && p5 <= 5'd15) begin
                    n_hts = {r_hts[23:0], i_item.data_byte};
                end else if (p5 == HB_FORMAT) begin
                    if (i_item.data_byte != r_fmt) n_fmt_bad = 1'b1;
                end else if (p5 == HB_FMT_HI) begin
                    n_scratch = i_item.data_byte;
                end else if (p5 == HB_FMT_LO) begin
                    if (fw[15:12] != r_rate || fw[9:0] != 10'(CHANNELS)) n_fmt_bad = 1'b1;
                end else if (p5 == HB_DEPTH) begin
                    if (i_item.data_byte != r_depth) n_fmt_bad = 1'b1;
                end else if (p5 == HB_LEN_HI) begin
                    n_dlen = {i_item.data_byte, 8'h00};
                end else if (p5 == HB_LEN_LO) begin
                    n_dlen = {r_dlen[15:8], i_item.data_byte};
                end else if (p5 == HB_LAST && r_verdict == aaf_pkg::ST_ACCEPTED) begin
                    priority if (r_sub_bad) n_verdict = aaf_pkg::ST_IGNORED;
                    else if (r_id_bad)      n_verdict = aaf_pkg::ST_OTHER;
                    else if (r_fmt_bad)     n_verdict = aaf_pkg::ST_FORMAT_ERR;
                    else                    n_verdict = aaf_pkg::ST_ACCEPTED;
                end else begin
                end
            end else if (r_pos >= HDR_END && r_pos < POS_MAX) begin
                if (r_verdict == aaf_pkg::ST_ACCEPTED && off < r_dlen) begin
                    n_asm = {r_asm[23:0], i_item.data_byte};
                    if (off[1:0] == 2'b11) begin
                        // store the finished word, close the block on its last channel
                        o_we    = 1'b1;
                        o_waddr = AW'(AW'(r_pslot) * AW'(CHANNELS) + AW'(r_chan));
                        o_wdata = n_asm;
                        if (r_chan == CW'(CHANNELS - 1)) begin
                            n_chan  = '0;
                            n_pend  = r_pend + 32'd1;
                            n_pslot = f_slot_inc(r_pslot);
                        end else begin
                            n_chan = r_chan + 1'b1;
                        end
                    end
                end
            end
            if (r_pos < POS_MAX) n_pos = r_pos + 16'd1;

            if (i_item.end_of_frame) begin
                n_pos = '0;
                if (r_pos >= HDR_END - 16'd1) begin
                    st = n_verdict;
                    if (st == aaf_pkg::ST_OTHER) begin
                        n_oth = r_oth + 32'd1;
                    end else if (st != aaf_pkg::ST_IGNORED) begin
                        if (r_seen && n_hseq != r_prev + 8'd1) begin
                            se = 1'b1;
                            n_seq = r_seq + 32'd1;
                        end
                        n_prev = n_hseq;
                        n_seen = 1'b1;
                        n_ts   = n_hts;
                        if (st == aaf_pkg::ST_FORMAT_ERR) begin
                            n_fmtc = r_fmtc + 32'd1;
                        end else begin
                            n_wp    = n_pend;
                            n_wslot = n_pslot;
                            n_acc   = r_acc + 32'd1;
                        end
                    end
                end
                o_push = 1'b1;
                o_cmd.kind = aaf_pkg::KIND_STATUS;
                o_cmd.status = st; o_cmd.seq_err = se; o_cmd.ts = n_ts;
                o_cmd.cnt_acc = n_acc; o_cmd.cnt_seq = n_seq;
                o_cmd.cnt_fmt = n_fmtc; o_cmd.cnt_oth = n_oth;
            end
        end

        if (sid_wr) begin
            n_acc = '0; n_seq = '0; n_fmtc = '0; n_seen = 1'b0;
            n_wp = '0; n_rp = '0; n_pend = '0;
            n_wslot = '0; n_rslot = '0; n_pslot = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en <= 1'b0; r_sid <= '0; r_fmt <= 8'd2; r_rate <= 4'd5; r_depth <= 8'd32;
            r_pos <= '0; r_sub_bad <= 1'b0; r_id_bad <= 1'b0; r_fmt_bad <= 1'b0;
            r_hseq <= '0; r_scratch <= '0; r_hts <= '0; r_asm <= '0;
            r_dlen <= '0; r_verdict <= '0; r_chan <= '0;
            r_pend <= '0; r_wp <= '0; r_rp <= '0;
            r_pslot <= '0; r_wslot <= '0; r_rslot <= '0;
            r_prev <= '0; r_seen <= 1'b0; r_ts <= '0;
            r_acc <= '0; r_seq <= '0; r_fmtc <= '0; r_oth <= '0;
            r_pops <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    aaf_pkg::REG_RX_ENABLE: r_en    <= i_cfg_data[0];
                    aaf_pkg::REG_STREAM_ID: r_sid   <= i_cfg_data;
                    aaf_pkg::REG_FORMAT:    r_fmt   <= i_cfg_data[7:0];
                    aaf_pkg::REG_RATE_CODE: r_rate  <= i_cfg_data[3:0];
                    aaf_pkg::REG_BIT_DEPTH: r_depth <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            r_pos <= n_pos; r_sub_bad <= n_sub_bad; r_id_bad <= n_id_bad;
            r_fmt_bad <= n_fmt_bad; r_hseq <= n_hseq; r_scratch <= n_scratch;
            r_hts <= n_hts; r_asm <= n_asm; r_dlen <= n_dlen; r_verdict <= n_verdict;
            r_chan <= n_chan; r_pend <= n_pend; r_wp <= n_wp; r_rp <= n_rp;
            r_pslot <= n_pslot; r_wslot <= n_wslot; r_rslot <= n_rslot;
            r_prev <= n_prev; r_seen <= n_seen; r_ts <= n_ts;
            r_acc <= n_acc; r_seq <= n_seq; r_fmtc <= n_fmtc; r_oth <= n_oth;
            // count sample pops still in flight; frame bytes hold while any remain
            r_pops <= r_pops
                    + 4'(o_push && o_cmd.kind == aaf_pkg::KIND_SAMPLE)
                    - 4'(i_pop_done);
        end
    end
endmodule

### sv/aaf_back.sv
module aaf_back #(
    parameter int CHANNELS    = aaf_pkg::CHANNELS_DEF,
    parameter int RING_BLOCKS = aaf_pkg::RING_BLOCKS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_valid,
    input  aaf_pkg::t_cmd                     i_cmd,
    output logic                              o_q_pop,
    output logic                              o_pop_done,
    output logic                              o_re,
    output logic [$clog2(RING_BLOCKS*CHANNELS)-1:0] o_raddr,
    input  logic [31:0]                       i_rdata,
    aaf_out_if.source                         o_result
);
    localparam int AW = $clog2(RING_BLOCKS * CHANNELS);
    localparam int SW = $clog2(RING_BLOCKS);
    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [CW-1:0] r_idx;
    logic          r_dv;
    aaf_pkg::t_cmd r_dcmd;
    logic [CW-1:0] r_dch;
    logic          r_dlast;
    logic          r_ov;
    logic          mv, issue, is_smp, smp_last;

    assign mv       = r_dv && (!r_ov || o_result.ready);
    assign issue    = i_q_valid && (!r_dv || mv);
    assign is_smp   = (i_cmd.kind == aaf_pkg::KIND_SAMPLE);
    assign smp_last = (r_idx == CW'(CHANNELS - 1));
    assign o_q_pop  = issue && (!is_smp || smp_last);
    assign o_pop_done = issue && is_smp && smp_last;
    assign o_re     = issue && is_smp;
    assign o_raddr  = AW'(AW'(i_cmd.slot[SW-1:0]) * AW'(CHANNELS) + AW'(r_idx));

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_dcmd  <= i_cmd;
            r_dch   <= r_idx;
            r_dlast <= !is_smp || smp_last;
        end
        if (mv) begin
            o_result.kind               <= r_dcmd.kind;
            o_result.channel            <= (r_dcmd.kind == aaf_pkg::KIND_SAMPLE)
                                           ? 3'(r_dch) : 3'd0;
            o_result.sample             <= (r_dcmd.kind == aaf_pkg::KIND_SAMPLE)
                                           ? i_rdata : 32'd0;
            o_result.last               <= r_dlast;
            o_result.frame_status       <= r_dcmd.status;
            o_result.sequence_error     <= r_dcmd.seq_err;
            o_result.avtp_ts            <= r_dcmd.ts;
            o_result.accepted_count     <= r_dcmd.cnt_acc;
            o_result.seq_error_count    <= r_dcmd.cnt_seq;
            o_result.format_error_count <= r_dcmd.cnt_fmt;
            o_result.other_stream_count <= r_dcmd.cnt_oth;
        end
        if (!i_rst_n) begin
            r_idx <= '0;
            r_dv  <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            if (issue && is_smp) begin
                r_idx <= smp_last ? '0 : r_idx + 1'b1;
            end
            if (issue)   r_dv <= 1'b1;
            else if (mv) r_dv <= 1'b0;
            if (mv)                   r_ov <= 1'b1;
            else if (o_result.ready)  r_ov <= 1'b0;
        end
    end

    assign o_result.valid = r_ov;
endmodule

### sv/aaf_stream_depacketizer_unit.sv
// Channel    Dir  Beat contents
// i_item     in   opcode (byte/pop), data_byte, end_of_frame
// o_result   out  kind, channel, sample, last, frame_status, sequence_error, 5 status words
// i_cfg_*    in   write enable, register index, 64-bit data
//
// Frame bytes are taken back to back while the queue has room; the
// header is parsed on the fly and samples are written to the ring as they complete.
// A pop gives CHANNELS result beats for a filled block, one per cycle unless stalled,
// set by the single ring read port. Frame bytes hold while a pop is still reading the
// ring. Reset is synchronous, active low, and clears all control and counters; the ring
// itself is not cleared. A stalled result holds in the output register; the queue takes
// up to Q_DEPTH more commands before the input stalls.
module aaf_stream_depacketizer_unit #(
    parameter int CHANNELS    = aaf_pkg::CHANNELS_DEF,
    parameter int RING_BLOCKS = aaf_pkg::RING_BLOCKS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    aaf_in_if.sink                         i_item,
    aaf_out_if.source                      o_result,
    input  logic                           i_cfg_we,
    input  logic [aaf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [aaf_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    localparam int AW = $clog2(RING_BLOCKS * CHANNELS);

    // front to queue
    logic          push, q_ready;
    aaf_pkg::t_cmd push_cmd;
    // queue to back
    logic          q_valid, q_pop, pop_done;
    aaf_pkg::t_cmd q_cmd;
    // ring ports
    logic          we, re;
    logic [AW-1:0] waddr, raddr;
    logic [31:0]   wdata, rdata;

    // parse, classify, update counters and write the ring
    aaf_front #(.CHANNELS(CHANNELS), .RING_BLOCKS(RING_BLOCKS)) u_front (
        .i_clk, .i_rst_n, .i_item,
        .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_q_ready(q_ready), .o_push(push), .o_cmd(push_cmd),
        .i_pop_done(pop_done),
        .o_we(we), .o_waddr(waddr), .o_wdata(wdata)
    );

    // decouple the result side from the byte side
    aaf_queue #(.DEPTH(aaf_pkg::Q_DEPTH)) u_queue (
        .i_clk, .i_rst_n,
        .i_push(push), .i_cmd(push_cmd), .o_ready(q_ready),
        .i_pop(q_pop), .o_valid(q_valid), .o_cmd(q_cmd)
    );

    aaf_ram #(.WIDTH(32), .DEPTH(RING_BLOCKS * CHANNELS)) u_ring (
        .i_clk, .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_re(re), .i_raddr(raddr), .o_rdata(rdata)
    );

    // expand commands into result beats
    aaf_back #(.CHANNELS(CHANNELS), .RING_BLOCKS(RING_BLOCKS)) u_back (
        .i_clk, .i_rst_n,
        .i_q_valid(q_valid), .i_cmd(q_cmd), .o_q_pop(q_pop), .o_pop_done(pop_done),
        .o_re(re), .o_raddr(raddr), .i_rdata(rdata), .o_result
    );
endmodule

### sv/aaf_chk.sv
module aaf_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [1:0]  i_kind,
    input logic        i_last,
    input logic [1:0]  i_status,
    input logic        i_seq_err,
    input logic [31:0] i_sample
);
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !i_valid)
        else $error("result beat right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_kind) && $stable(i_sample))
        else $error("stalled result beat changed");

    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind != 2'd0 |-> i_last)
        else $error("status or empty beat not marked last");

    a_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind != 2'd1 |-> i_status == 2'd0 && !i_seq_err)
        else $error("status fields set outside a status beat");
endmodule

bind aaf_stream_depacketizer_unit aaf_chk u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_valid(o_result.valid), .i_ready(o_result.ready),
    .i_kind(o_result.kind), .i_last(o_result.last),
    .i_status(o_result.frame_status), .i_seq_err(o_result.sequence_error),
    .i_sample(o_result.sample)
);

### dv/depkt_checker.sv
`timescale 1ns / 100ps

// Watches the item, result and register channels, keeps its own copy of the
// depacketizer state and compares every result beat with the oldest prediction.
module depkt_checker
    import aaf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    aaf_in_if                     in_ch,
    aaf_out_if                    out_ch,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_errors,
    output int                    o_pending
);

    localparam int NCH   = CHANNELS_DEF;
    localparam int NBLK  = RING_BLOCKS_DEF;
    localparam int HDR_0 = 14;
    localparam int DAT_0 = 38;

    typedef struct {
        t_kind       kind;
        logic [2:0]  chan;
        logic [31:0] smp;
        logic        last;
        logic [1:0]  status;
        logic        seq_err;
        logic [31:0] ts;
        logic [31:0] n_acc;
        logic [31:0] n_seq;
        logic [31:0] n_fmt;
        logic [31:0] n_oth;
    } t_result;

    t_result expected_results[$];

    // mirror of the receive state
    logic [31:0] ring_mirror [NBLK*NCH];
    logic [15:0] byte_idx;
    logic        bad_subtype, bad_id, bad_fmt;
    logic [7:0]  frame_seq, rate_hi;
    logic [31:0] ts_acc;
    logic [1:0]  verdict;
    logic [15:0] dlen;
    logic [31:0] smp_acc;
    logic [31:0] wp_pend, wp, rp;
    logic [7:0]  prev_seq;
    logic        seq_valid;
    logic [31:0] ts_kept;
    logic [31:0] n_acc, n_seq, n_fmt, n_oth;

    // register copies
    logic        rx_on;
    logic [63:0] bound_id;
    logic [7:0]  want_fmt;
    logic [3:0]  want_rate;
    logic [7:0]  want_depth;

    int errors;

    function automatic void clear_state();
        byte_idx = '0; bad_subtype = 0; bad_id = 0; bad_fmt = 0;
        frame_seq = '0; rate_hi = '0; ts_acc = '0; verdict = ST_ACCEPTED;
        dlen = '0; smp_acc = '0; wp_pend = '0; wp = '0; rp = '0;
        prev_seq = '0; seq_valid = 0; ts_kept = '0;
        n_acc = '0; n_seq = '0; n_fmt = '0; n_oth = '0;
        rx_on = 0; bound_id = '0; want_fmt = 8'd2; want_rate = 4'd5; want_depth = 8'd32;
        expected_results.delete();
    endfunction

    function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        case (idx)
            REG_RX_ENABLE: rx_on = val[0];
            REG_STREAM_ID: begin
                bound_id = val;
                n_acc = '0; n_seq = '0; n_fmt = '0;
                seq_valid = 0;
                wp = '0; rp = '0; wp_pend = '0;
            end
            REG_FORMAT:    want_fmt = val[7:0];
            REG_RATE_CODE: want_rate = val[3:0];
            REG_BIT_DEPTH: want_depth = val[7:0];
            default: ;
        endcase
    endfunction

    function automatic void push_result(t_kind k, int ch, logic [31:0] s, logic l,
                                        logic [1:0] st, logic se);
        t_result r;
        r.kind = k; r.chan = ch[2:0]; r.smp = s; r.last = l; r.status = st;
        r.seq_err = se; r.ts = ts_kept; r.n_acc = n_acc; r.n_seq = n_seq;
        r.n_fmt = n_fmt; r.n_oth = n_oth;
        expected_results.push_back(r);
    endfunction

    function automatic void parse_header(int p, logic [7:0] b);
        logic [15:0] w;
        if (p == 0) begin
            if (b != 8'h02) bad_subtype = 1;
        end else if (p == 2) begin
            frame_seq = b;
        end else if (p >= 4 && p <= 11) begin
            if (b != bound_id[63 - 8*(p-4) -: 8]) bad_id = 1;
        end else if (p >= 12 && p <= 15) begin
            ts_acc = {ts_acc[23:0], b};
        end else if (p == 16) begin
            if (b != want_fmt) bad_fmt = 1;
        end else if (p == 17) begin
            rate_hi = b;
        end else if (p == 18) begin
            w = {rate_hi, b};
            if (w[15:12] != want_rate || w[9:0] != 10'(NCH)) bad_fmt = 1;
        end else if (p == 19) begin
            if (b != want_depth) bad_fmt = 1;
        end else if (p == 20) begin
            dlen = {b, 8'h00};
        end else if (p == 21) begin
            dlen[7:0] = b;
        end else if (p == 23 && verdict == ST_ACCEPTED) begin
            if (bad_subtype)  verdict = ST_IGNORED;
            else if (bad_id)  verdict = ST_OTHER;
            else if (bad_fmt) verdict = ST_FORMAT_ERR;
        end
    endfunction

    function automatic void store_payload(int off, logic [7:0] b);
        int ch, slot;
        if (verdict != ST_ACCEPTED || off >= dlen) return;
        smp_acc = {smp_acc[23:0], b};
        if (off[1:0] == 2'd3) begin
            ch = (off >> 2) % NCH;
            slot = wp_pend % NBLK;
            ring_mirror[slot*NCH + ch] = smp_acc;
            if (ch == NCH - 1) wp_pend++;
        end
    endfunction

    function automatic void predict_beat(logic op, logic [7:0] b, logic eof);
        int pos, slot;
        logic [1:0] st;
        logic se;
        if (op == OP_POP) begin
            if (wp == rp) begin
                push_result(KIND_EMPTY, 0, '0, 1, ST_ACCEPTED, 0);
                return;
            end
            slot = rp % NBLK;
            for (int c = 0; c < NCH; c++)
                push_result(KIND_SAMPLE, c, ring_mirror[slot*NCH + c], c == NCH - 1,
                            ST_ACCEPTED, 0);
            rp++;
            return;
        end
        pos = byte_idx;
        st = ST_IGNORED;
        se = 0;
        if (pos == 0) begin
            wp_pend = wp; dlen = '0; smp_acc = '0;
            bad_subtype = 0; bad_id = 0; bad_fmt = 0;
            frame_seq = '0; rate_hi = '0; ts_acc = '0;
            verdict = rx_on ? ST_ACCEPTED : ST_IGNORED;
        end
        if (pos >= HDR_0 && pos < DAT_0) parse_header(pos - HDR_0, b);
        else if (pos >= DAT_0 && pos < 16'hFFFF) store_payload(pos - DAT_0, b);
        if (pos < 16'hFFFF) byte_idx = 16'(pos + 1);
        if (!eof) return;
        byte_idx = '0;
        if (pos + 1 >= DAT_0) begin
            st = verdict;
            if (st == ST_OTHER) begin
                n_oth++;
            end else if (st != ST_IGNORED) begin
                if (seq_valid && frame_seq != 8'(prev_seq + 1)) begin
                    se = 1;
                    n_seq++;
                end
                prev_seq = frame_seq;
                seq_valid = 1;
                ts_kept = ts_acc;
                if (st == ST_FORMAT_ERR) begin
                    n_fmt++;
                end else begin
                    wp = wp_pend;
                    n_acc++;
                end
            end
        end
        push_result(KIND_STATUS, 0, '0, 1, st, se);
    endfunction

    function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
        if (exp !== act) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp, act);
            errors++;
        end
    endfunction

    function automatic void check_result();
        t_result r;
        if (expected_results.size() == 0) begin
            $display("%0t: result beat with nothing expected, kind %0d", $time, out_ch.kind);
            errors++;
            return;
        end
        r = expected_results.pop_front();
        check_field("kind", 32'(r.kind), 32'(out_ch.kind));
        check_field("channel", 32'(r.chan), 32'(out_ch.channel));
        check_field("sample", r.smp, out_ch.sample);
        check_field("last", 32'(r.last), 32'(out_ch.last));
        check_field("frame_status", 32'(r.status), 32'(out_ch.frame_status));
        check_field("sequence_error", 32'(r.seq_err), 32'(out_ch.sequence_error));
        check_field("avtp_ts", r.ts, out_ch.avtp_ts);
        check_field("accepted_count", r.n_acc, out_ch.accepted_count);
        check_field("seq_error_count", r.n_seq, out_ch.seq_error_count);
        check_field("format_error_count", r.n_fmt, out_ch.format_error_count);
        check_field("other_stream_count", r.n_oth, out_ch.other_stream_count);
    endfunction

    initial begin
        errors = 0;
        clear_state();
        o_errors = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_state();
        end else begin
            if (out_ch.valid && out_ch.ready) check_result();
            if (i_cfg_we) apply_cfg(i_cfg_index, i_cfg_data);
            if (in_ch.valid && in_ch.ready)
                predict_beat(in_ch.opcode, in_ch.data_byte, in_ch.end_of_frame);
        end
        o_errors = errors;
        o_pending = expected_results.size();
    end

endmodule

### dv/tb.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the AAF depacketizer. The checker beside the block
// does all prediction; this module drives frames, pops, register writes and ready.
module tb;
    import aaf_pkg::*;

    localparam int QUIET_LIMIT = 4000;  // cycles without any beat before giving up
    localparam int DRAIN_WAIT  = 30;    // settle time once nothing is expected
    localparam int LONG_HOLD   = 400;   // receiver back-pressure stretch

    typedef enum int {FR_GOOD, FR_SUBTYPE, FR_OTHER, FR_FORMAT, FR_SHORT} t_frame_mode;
    typedef enum int {PL_RANDOM, PL_ZEROS, PL_ONES} t_payload;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    errors, pending, quiet;

    logic                  hold_req;
    int                    tx_run, rx_run;   // remaining beats with no idling
    int                    items;

    // our view of the programmed registers, used to build matching headers
    logic [63:0]           cur_id;
    logic [7:0]            cur_fmt, cur_depth, tx_seq;
    logic [3:0]            cur_rate;

    aaf_in_if  in_ch();
    aaf_out_if out_ch();

    aaf_stream_depacketizer_unit u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_item     (in_ch),
        .o_result   (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    depkt_checker u_chk (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    always begin
        clk = 1'b1; #5;
        clk = 1'b0; #5;
    end

    // Abort when nothing moves on any channel for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // Result receiver: random stalls per beat, stretches without stalls, and one
    // long hold-off on request so the block backs up into its input.
    initial begin : result_sink
        int gap;
        bit held;
        out_ch.ready = 1'b0;
        rx_run = 0;
        held = 1'b0;
        forever begin
            if (hold_req && !held) begin
                out_ch.ready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                held = 1'b1;
            end
            if (rx_run > 0) begin
                rx_run--;
                gap = 0;
            end else begin
                if ($urandom_range(0, 19) == 0) rx_run = 40;
                gap = $urandom_range(0, 4);
            end
            if (gap > 0) begin
                out_ch.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ch.ready = 1'b1;
            do @(posedge clk); while (!out_ch.valid);
            @(negedge clk);
        end
    end

    // Drive one beat: idle first, then hold it until the block takes it.
    task automatic put_beat(logic op, logic [7:0] b, logic eof);
        int gap;
        if (tx_run > 0) begin
            tx_run--;
            gap = 0;
        end else begin
            if ($urandom_range(0, 29) == 0) tx_run = 60;
            gap = $urandom_range(0, 4);
        end
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid        = 1'b1;
        in_ch.opcode       = op;
        in_ch.data_byte    = b;
        in_ch.end_of_frame = eof;
        do @(posedge clk); while (!in_ch.ready);
        @(negedge clk);
        in_ch.valid = 1'b0;
        items++;
    endtask

    // Pops ignore the byte and end flag, so randomise both.
    task automatic pop_block();
        put_beat(OP_POP, 8'($urandom), 1'($urandom));
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // Let every expected result drain, plus the block's own latency.
    task automatic wait_idle();
        wait (pending == 0);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic bind_stream(logic [63:0] id, logic [7:0] fmt, logic [3:0] rate,
                               logic [7:0] depth);
        wait_idle();
        write_reg(REG_STREAM_ID, id);
        write_reg(REG_FORMAT, {56'd0, fmt});
        write_reg(REG_RATE_CODE, {60'd0, rate});
        write_reg(REG_BIT_DEPTH, {56'd0, depth});
        cur_id = id; cur_fmt = fmt; cur_rate = rate; cur_depth = depth;
    endtask

    // Build one frame and send it byte by byte, with stray pops in between.
    task automatic send_frame(t_frame_mode mode, int plen, int dlen, t_payload fill,
                              bit pops);
        logic [7:0] f[$];
        logic [7:0] b;
        int cut, which;
        repeat (14) f.push_back(8'($urandom));
        if (mode == FR_SUBTYPE) begin
            do b = 8'($urandom); while (b == 8'h02);
            f.push_back(b);
        end else begin
            f.push_back(8'h02);
        end
        f.push_back(8'($urandom));
        f.push_back(tx_seq);
        f.push_back(8'($urandom));
        which = $urandom_range(0, 7);
        for (int i = 0; i < 8; i++) begin
            b = cur_id[63 - 8*i -: 8];
            if (mode == FR_OTHER && i == which) b ^= 8'(1 << $urandom_range(0, 7));
            f.push_back(b);
        end
        repeat (4) f.push_back(8'($urandom));
        which = (mode == FR_FORMAT) ? $urandom_range(0, 4) : -1;
        f.push_back(which == 0 ? cur_fmt ^ 8'($urandom_range(1, 255)) : cur_fmt);
        // rate in the top nibble, two ignored bits, then the channel count
        b = {cur_rate, 2'($urandom), 2'b00};
        if (which == 1) b[7:4] ^= 4'($urandom_range(1, 15));
        if (which == 2) b[1:0] = 2'($urandom_range(1, 3));
        f.push_back(b);
        f.push_back(which == 3 ? 8'(8 ^ $urandom_range(1, 255)) : 8'd8);
        f.push_back(which == 4 ? cur_depth ^ 8'($urandom_range(1, 255)) : cur_depth);
        f.push_back(8'(dlen >> 8));
        f.push_back(8'(dlen));
        repeat (2) f.push_back(8'($urandom));
        for (int i = 0; i < plen; i++)
            f.push_back(fill == PL_ZEROS ? 8'h00 : fill == PL_ONES ? 8'hFF : 8'($urandom));
        if (mode == FR_SHORT) begin
            cut = $urandom_range(1, 37);
            while (f.size() > cut) void'(f.pop_back());
        end
        foreach (f[i]) begin
            if (pops && $urandom_range(0, 39) == 0) pop_block();
            put_beat(OP_BYTE, f[i], i == f.size() - 1);
        end
        // advance the sequence, with an occasional gap
        tx_seq = tx_seq + 8'd1 + (($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'd0);
    endtask

    initial begin : stimulus
        in_ch.valid = 1'b0; in_ch.opcode = OP_BYTE; in_ch.data_byte = '0;
        in_ch.end_of_frame = 1'b0;
        cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        hold_req = 1'b0; tx_run = 0; items = 0;
        cur_id = '0; cur_fmt = 8'd2; cur_rate = 4'd5; cur_depth = 8'd32; tx_seq = '0;
        rst_n = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Receive still disabled, so a well-formed frame is ignored.
        send_frame(FR_GOOD, 0, 0, PL_RANDOM, 1'b0);
        wait_idle();
        write_reg(REG_RX_ENABLE, 64'd1);
        send_frame(FR_SHORT, 0, 0, PL_RANDOM, 1'b0);
        send_frame(FR_SUBTYPE, 0, 0, PL_RANDOM, 1'b0);
        send_frame(FR_OTHER, 0, 0, PL_RANDOM, 1'b0);
        send_frame(FR_FORMAT, 0, 0, PL_RANDOM, 1'b0);
        // one whole block, then one word of a block that is never committed
        send_frame(FR_GOOD, 36, 36, PL_ONES, 1'b1);

        // Receiver backs off while pops keep coming: the first drains the block,
        // the rest find the ring empty and pile up until the input stalls.
        hold_req = 1'b1;
        repeat (7) pop_block();

        // New stream and format settings; data length shorter than the payload.
        bind_stream({$urandom, $urandom}, 8'h11, 4'h3, 8'h18);
        send_frame(FR_GOOD, 34, 32, PL_RANDOM, 1'b1);
        repeat (2) pop_block();

        wait_idle();
        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

### sim.f
sv/aaf_pkg.sv
sv/aaf_in_if.sv
sv/aaf_out_if.sv
sv/aaf_ram.sv
sv/aaf_queue.sv
sv/aaf_front.sv
sv/aaf_back.sv
sv/aaf_stream_depacketizer_unit.sv
sv/aaf_chk.sv
dv/depkt_checker.sv
dv/tb.sv
